// File: hw/rtl/dblc_pkg.sv
package dblc_pkg;

    localparam int COUNTER_BITS_DEFAULT = 10;
    localparam int CFG_BITS = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int STATE_BITS = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_BUZZER   = 2'd1,
        CFG_PERIOD   = 2'd2
    } cfg_index_t;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 10'd50;
    localparam logic [CFG_BITS-1:0] BUZZER_RESET   = 10'd300;
    localparam logic [CFG_BITS-1:0] PERIOD_RESET   = 10'd20;

    localparam logic [STATE_BITS-1:0] ST_LOW_VOLTAGE = 8'd0;
    localparam logic [STATE_BITS-1:0] ST_HV_ENABLED  = 8'd1;
    localparam logic [STATE_BITS-1:0] ST_READY       = 8'd2;
    localparam logic [STATE_BITS-1:0] ST_ERROR       = 8'd3;

    localparam int BTN_HV    = 0;
    localparam int BTN_DRIVE = 1;
    localparam int BTN_RESET = 2;
    localparam int BTN_DAQ   = 3;

    typedef struct packed {
        logic                  hv_button;
        logic                  drive_button;
        logic                  reset_button;
        logic                  daq_button;
        logic                  heartbeat_valid;
        logic [STATE_BITS-1:0] heartbeat_state;
    } in_item_t;

    typedef struct packed {
        logic                  hv_request;
        logic                  drive_request;
        logic                  clear_request;
        logic                  daq_enable;
        logic [STATE_BITS-1:0] reported_state;
        logic                  hv_lamp;
        logic                  drive_lamp;
        logic                  reset_lamp;
        logic                  daq_lamp;
        logic                  error_lamp;
        logic                  buzzer_on;
        logic                  display_refresh;
    } out_item_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_ticks;
        logic [CFG_BITS-1:0] buzzer_ticks;
        logic [CFG_BITS-1:0] display_period;
    } cfg_t;

endpackage

// File: hw/rtl/dblc_core.sv
module dblc_core #(
    parameter int COUNTER_BITS = dblc_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  dblc_pkg::in_item_t  item,
    input  dblc_pkg::cfg_t      cfg,
    output dblc_pkg::out_item_t result
);

    localparam int CW = (COUNTER_BITS > dblc_pkg::CFG_BITS) ? COUNTER_BITS
                                                              : dblc_pkg::CFG_BITS;
    localparam logic [CW-1:0] TOP_EXT = CW'({COUNTER_BITS{1'b1}});

    logic [3:0]                      button_now_reg, button_now_next;
    logic [COUNTER_BITS-1:0]         holdoff_reg, holdoff_next;
    logic [COUNTER_BITS-1:0]         buzz_reg, buzz_next;
    logic [COUNTER_BITS-1:0]         refresh_reg, refresh_next;
    logic [dblc_pkg::STATE_BITS-1:0] vstate_reg, vstate_next;
    logic                            daq_flag_reg, daq_flag_next;
    logic [4:0]                      lamps_reg, lamps_next;  // hv, drive, reset, error, buzz

    logic [COUNTER_BITS-1:0] deb, buz, per;
    logic [4:0]              edges;
    logic [4:0]              taken;

    function automatic logic [COUNTER_BITS-1:0] clip(input logic [dblc_pkg::CFG_BITS-1:0] v);
        logic [CW-1:0] v_ext;
        v_ext = CW'(v);
        return (v_ext > TOP_EXT) ? COUNTER_BITS'(TOP_EXT) : COUNTER_BITS'(v_ext);
    endfunction

    assign deb = clip(cfg.debounce_ticks);
    assign buz = clip(cfg.buzzer_ticks);
    assign per = clip(cfg.display_period);

    always_comb
    begin
        logic [COUNTER_BITS-1:0] h;
        logic [dblc_pkg::STATE_BITS-1:0] st;

        button_now_next = {item.daq_button, item.reset_button,
                           item.drive_button, item.hv_button};

        // edges in priority order: hv, drive, reset, daq press, daq release
        edges[0] = button_now_next[dblc_pkg::BTN_HV] & ~button_now_reg[dblc_pkg::BTN_HV];
        edges[1] = button_now_next[dblc_pkg::BTN_DRIVE]
                   & ~button_now_reg[dblc_pkg::BTN_DRIVE];
        edges[2] = button_now_next[dblc_pkg::BTN_RESET]
                   & ~button_now_reg[dblc_pkg::BTN_RESET];
        edges[3] = button_now_next[dblc_pkg::BTN_DAQ] & ~button_now_reg[dblc_pkg::BTN_DAQ];
        edges[4] = ~button_now_next[dblc_pkg::BTN_DAQ] & button_now_reg[dblc_pkg::BTN_DAQ];

        h = holdoff_reg;
        if (h < deb && button_now_next == 4'b0000)
        begin
            h = h + 1'b1;
        end

        // each accepted edge clears the hold-off, refusing later ones
        for (int i = 0; i < 5; i++)
        begin
            taken[i] = edges[i] && (h >= deb);
            if (taken[i])
            begin
                h = '0;
            end
        end
        holdoff_next = h;

        daq_flag_next = daq_flag_reg;
        if (taken[3])
        begin
            daq_flag_next = 1'b1;
        end
        if (taken[4])
        begin
            daq_flag_next = 1'b0;
        end

        st = vstate_reg;
        lamps_next   = lamps_reg;
        buzz_next    = buzz_reg;
        refresh_next = refresh_reg;
        result.display_refresh = 1'b0;
        if (st <= dblc_pkg::ST_ERROR)
        begin
            lamps_next[0] = (st == dblc_pkg::ST_HV_ENABLED) || (st == dblc_pkg::ST_READY);
            lamps_next[1] = (st == dblc_pkg::ST_READY);
            lamps_next[2] = (st != dblc_pkg::ST_ERROR);
            lamps_next[3] = (st == dblc_pkg::ST_ERROR);
            if (st == dblc_pkg::ST_READY)
            begin
                if (buzz_reg < buz)
                begin
                    lamps_next[4] = 1'b1;
                    buzz_next     = buzz_reg + 1'b1;
                end
                else
                begin
                    lamps_next[4] = 1'b0;
                end
            end
            else
            begin
                lamps_next[4] = 1'b0;
                buzz_next     = '0;
            end
            if (refresh_reg >= per)
            begin
                result.display_refresh = 1'b1;
                refresh_next           = '0;
            end
            else
            begin
                refresh_next = refresh_reg + 1'b1;
            end
        end

        vstate_next = item.heartbeat_valid ? item.heartbeat_state : vstate_reg;

        result.hv_request     = taken[0];
        result.drive_request  = taken[1];
        result.clear_request  = taken[2];
        result.daq_enable     = daq_flag_next;
        result.reported_state = vstate_next;
        result.hv_lamp        = lamps_next[0];
        result.drive_lamp     = lamps_next[1];
        result.reset_lamp     = lamps_next[2];
        result.daq_lamp       = daq_flag_next;
        result.error_lamp     = lamps_next[3];
        result.buzzer_on      = lamps_next[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_now_reg    <= '0;
            holdoff_reg       <= '0;
            buzz_reg          <= '0;
            refresh_reg       <= '0;
            vstate_reg        <= dblc_pkg::ST_LOW_VOLTAGE;
            daq_flag_reg      <= 1'b0;
            lamps_reg         <= '0;
        end
        else if (advance)
        begin
            button_now_reg    <= button_now_next;
            holdoff_reg       <= holdoff_next;
            buzz_reg          <= buzz_next;
            refresh_reg       <= refresh_next;
            vstate_reg        <= vstate_next;
            daq_flag_reg      <= daq_flag_next;
            lamps_reg         <= lamps_next;
        end
    end

endmodule

// File: hw/rtl/dblc_out_queue.sv
module dblc_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dblc_pkg::out_item_t push_data,
    output logic                full,
    output logic                valid,
    input  logic                stall,
    output dblc_pkg::out_item_t data
);

    dblc_pkg::out_item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign valid = (count_reg != 2'd0);
    assign full  = (count_reg == 2'd2);
    assign pop   = valid && !stall;
    assign data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/dashboard_button_and_lamp_controller.sv
// Dashboard button and lamp controller: one input transaction per 10 ms tick carries the
// four button levels and an optional heartbeat state; one result transaction comes back
// for each, in order. A tick is taken every clock cycle when the output is drained; a
// tick waits in the input register, then the logic writes its result into a two-entry
// output queue, from which the result is offered. in_stall rises only when the output
// queue is full and a tick already waits in the input register. Configuration (debounce,
// buzzer and display period, each clipped to the COUNTER_BITS counter range) is written
// through cfg_write/cfg_index/cfg_data; the user must write it only while no tick is in
// flight, and the block itself does not enforce this. Unknown indexes are ignored.
module dashboard_button_and_lamp_controller #(
    parameter int COUNTER_BITS = dblc_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  dblc_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output dblc_pkg::out_item_t                   out_data,
    input  logic                                  cfg_write,
    input  logic [dblc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dblc_pkg::CFG_BITS-1:0]         cfg_data
);

    dblc_pkg::cfg_t      cfg_reg, cfg_next;
    logic                s1_valid_reg, s1_valid_next;
    dblc_pkg::in_item_t  s1_data_reg;
    dblc_pkg::out_item_t result;
    logic                q_full;
    logic                advance;
    logic                in_accept;

    assign in_stall  = s1_valid_reg && q_full;
    assign in_accept = in_valid && !in_stall;
    assign advance   = s1_valid_reg && !q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                dblc_pkg::CFG_DEBOUNCE: cfg_next.debounce_ticks = cfg_data;
                dblc_pkg::CFG_BUZZER:   cfg_next.buzzer_ticks   = cfg_data;
                dblc_pkg::CFG_PERIOD:   cfg_next.display_period = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
        s1_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= dblc_pkg::DEBOUNCE_RESET;
            cfg_reg.buzzer_ticks   <= dblc_pkg::BUZZER_RESET;
            cfg_reg.display_period <= dblc_pkg::PERIOD_RESET;
            s1_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // hold the tick until the queue has room
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
        end
    end

    dblc_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (s1_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    dblc_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (advance),
        .push_data(result),
        .full     (q_full),
        .valid    (out_valid),
        .stall    (out_stall),
        .data     (out_data)
    );

endmodule

// File: hw/rtl/dblc_checker.sv
module dblc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input dblc_pkg::in_item_t                  in_data,
    input logic                                out_valid,
    input logic                                out_stall,
    input dblc_pkg::out_item_t                 out_data,
    input logic                                cfg_write,
    input logic [dblc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [dblc_pkg::CFG_BITS-1:0]       cfg_data
);

    logic unused_inputs;
    assign unused_inputs = ^{in_valid, in_data, cfg_write, cfg_index, cfg_data};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result transaction changed while stalled");

    // input backs up only behind a full output
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_daq_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.daq_lamp == out_data.daq_enable)
        else $error("DAQ lamp differs from DAQ flag");

    a_lamp_combo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.error_lamp
                       || !(out_data.hv_lamp || out_data.drive_lamp || out_data.reset_lamp))
                      && (!out_data.drive_lamp || out_data.hv_lamp)
                      && (!out_data.buzzer_on || out_data.drive_lamp))
        else $error("inconsistent lamp pattern");

endmodule

bind dashboard_button_and_lamp_controller dblc_checker u_dblc_checker (.*);
